// ===== hw/rtl/scpd_pkg.sv =====
// Package for the shift register port chain driver.
// Holds request codes, sizes and the controller/datapath command and status types.
// Depends on nothing.
`default_nettype none

package scpd_pkg;

  localparam int CHIP_BITS     = 8;
  localparam int NUM_PORTS_DEF = 32;
  localparam int IDX_W         = 5;
  localparam int REQ_W         = 2;
  localparam int BW_W          = 4;
  localparam int CNT_W         = 4;

  localparam logic [REQ_W-1:0] REQ_ENABLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UPDATE  = 2'd2;

  localparam logic [1:0] ADDR_BIT_WIDTH = 2'd0;
  localparam logic [BW_W-1:0] BIT_WIDTH_RST = 4'd8;

  typedef struct packed {
    logic apply;   // take the accepted request
    logic start;   // begin an update walk
    logic emit;    // load the next word into the output register
  } cmd_t;

  typedef struct packed {
    logic upd_go;    // an update would send something
    logic last_word; // current word is the final one
    logic out_free;  // output register can take a word
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/shift_register_port_chain_driver.sv =====
// Top level of the shift register port chain driver: APB register, controller
// and datapath. Depends on scpd_pkg, scpd_ctrl and scpd_dp.
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid/tready           tuser req_type, tdata port_index
//   m_axis    out        tvalid/tready           tdata shift_bits, bit_count; tlast last
//   apb       in         psel/penable/pready     bit_width at address 0
//
// Enable and disable requests are taken while idle. An update is accepted and
// then emits one chip word per cycle, ceil(port_count / bit_width) words,
// from the single word-forming stage; a stalled output holds the walk.
// Reset clears the port table, the sent copy and bit_width to 8.
`default_nettype none

module shift_register_port_chain_driver #(
  parameter int NUM_PORTS = scpd_pkg::NUM_PORTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [4:0] port_index
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] shift_bits, [11:8] bit_count
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import scpd_pkg::*;

  logic [BW_W-1:0]      bit_width_q;
  cmd_t                 cmd;
  status_t              status;
  logic [CHIP_BITS-1:0] shift_bits;
  logic [CNT_W-1:0]     bit_count;

  assign pready = 1'b1;
  assign prdata = {{(32-BW_W){1'b0}}, bit_width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_width_q <= BIT_WIDTH_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_BIT_WIDTH) begin
      bit_width_q <= pwdata[BW_W-1:0];
    end
  end

  scpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_type_i  (s_axis_tuser),
    .status_i    (status),
    .req_ready_o (s_axis_tready),
    .cmd_o       (cmd)
  );

  scpd_dp #(
    .NUM_PORTS (NUM_PORTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (s_axis_tuser),
    .port_index_i (s_axis_tdata[IDX_W-1:0]),
    .bit_width_i  (bit_width_q),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .shift_bits_o (shift_bits),
    .bit_count_o  (bit_count),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {(16-CHIP_BITS-CNT_W)'(0), bit_count, shift_bits};

`ifndef SYNTHESIS
  a_no_req_during_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !s_axis_tready)
    else $error("request taken during update walk");

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("word loaded over a waiting word");

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && status.last_word |=> m_axis_tvalid && m_axis_tlast && s_axis_tready)
    else $error("final word not marked or walk not ended");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/scpd_ctrl.sv =====
// Controller state machine for the shift register port chain driver.
// Sequences request intake and word emission; depends on scpd_pkg.
`default_nettype none

module scpd_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    req_valid_i,
  input  wire logic [scpd_pkg::REQ_W-1:0] req_type_i,
  input  wire scpd_pkg::status_t       status_i,
  output logic                         req_ready_o,
  output scpd_pkg::cmd_t               cmd_o
);
  import scpd_pkg::*;

  typedef enum logic {ST_IDLE, ST_EMIT} state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.apply = 1'b1;
          if (req_type_i == REQ_UPDATE && status_i.upd_go) begin
            cmd_o.start = 1'b1;
            state_d     = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_word) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scpd_dp.sv =====
// Datapath for the shift register port chain driver: port table, sent copy,
// walk register and output word register. Depends on scpd_pkg.
`default_nettype none

module scpd_dp #(
  parameter int NUM_PORTS = scpd_pkg::NUM_PORTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire scpd_pkg::cmd_t              cmd_i,
  input  wire logic [scpd_pkg::REQ_W-1:0]  req_type_i,
  input  wire logic [scpd_pkg::IDX_W-1:0]  port_index_i,
  input  wire logic [scpd_pkg::BW_W-1:0]   bit_width_i,
  output scpd_pkg::status_t                status_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [scpd_pkg::CHIP_BITS-1:0]   shift_bits_o,
  output logic [scpd_pkg::CNT_W-1:0]       bit_count_o,
  output logic                             last_o
);
  import scpd_pkg::*;

  localparam int PC_W = $clog2(NUM_PORTS + 1);
  localparam int WK_W = NUM_PORTS + CHIP_BITS;
  localparam int RW   = (PC_W > BW_W) ? PC_W : BW_W;

  logic [NUM_PORTS-1:0] port_bits_q, port_bits_d, sent_bits_q;
  logic [PC_W-1:0]      port_count_q, port_count_d, sent_count_q;
  logic [WK_W-1:0]      work_q;
  logic [PC_W-1:0]      remain_q;
  logic                 out_valid_q;
  logic [CHIP_BITS-1:0] shift_bits_q;
  logic [CNT_W-1:0]     bit_count_q;
  logic                 last_q;

  logic [NUM_PORTS-1:0] sel;
  logic                 idx_ok;
  logic [IDX_W:0]       idx_p1;
  logic                 full;
  logic [BW_W-1:0]      n;
  logic [BW_W-1:0]      pad;
  logic [CHIP_BITS-1:0] top8, word;
  logic [CNT_W-1:0]     cnt;
  logic                 last_word;

  // request handling on the table
  always_comb begin
    sel          = NUM_PORTS'(1) << port_index_i;
    idx_ok       = {1'b0, port_index_i} < (IDX_W+1)'(NUM_PORTS);
    idx_p1       = {1'b0, port_index_i} + (IDX_W+1)'(1);
    port_bits_d  = port_bits_q;
    port_count_d = port_count_q;
    if (cmd_i.apply && idx_ok && (req_type_i == REQ_ENABLE || req_type_i == REQ_DISABLE)) begin
      if (req_type_i == REQ_ENABLE) begin
        port_bits_d = port_bits_q | sel;
      end else begin
        port_bits_d = port_bits_q & ~sel;
      end
      if ((IDX_W+1)'(port_count_q) < idx_p1) begin
        port_count_d = PC_W'(idx_p1);
      end
    end
  end

  // word formation from the top of the walk register
  always_comb begin
    full      = RW'(remain_q) >= RW'(bit_width_i);
    n         = full ? bit_width_i : BW_W'(remain_q);
    pad       = full ? (BW_W'(CHIP_BITS) - bit_width_i) : '0;
    top8      = work_q[WK_W-1 -: CHIP_BITS];
    word      = (top8 & (CHIP_BITS'(8'hFF) << (BW_W'(CHIP_BITS) - n))) >> pad;
    cnt       = full ? CNT_W'(CHIP_BITS) : CNT_W'(n);
    last_word = RW'(remain_q) == RW'(n);
  end

  assign status_o.upd_go = !(port_bits_q == sent_bits_q && port_count_q == sent_count_q)
                           && (port_count_q != '0) && (bit_width_i != '0)
                           && (bit_width_i <= BW_W'(CHIP_BITS));
  assign status_o.last_word = last_word;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_bits_q  <= '0;
      port_count_q <= '0;
      sent_bits_q  <= '0;
      sent_count_q <= '0;
      remain_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      port_bits_q  <= port_bits_d;
      port_count_q <= port_count_d;
      if (cmd_i.start) begin
        remain_q <= port_count_q;
      end else if (cmd_i.emit) begin
        remain_q <= remain_q - PC_W'(n);
      end
      if (cmd_i.emit && last_word) begin
        sent_bits_q  <= port_bits_q;
        sent_count_q <= port_count_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      work_q <= {port_bits_q, CHIP_BITS'(0)} << (PC_W'(NUM_PORTS) - port_count_q);
    end else if (cmd_i.emit) begin
      work_q <= work_q << n;
    end
    if (cmd_i.emit) begin
      shift_bits_q <= word;
      bit_count_q  <= cnt;
      last_q       <= last_word;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign shift_bits_o = shift_bits_q;
  assign bit_count_o  = bit_count_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for shift_register_port_chain_driver: directed table then random
// enable/disable/update/unknown requests, with chip words predicted in-bench and compared in order.
// Depends on scpd_pkg and the shift_register_port_chain_driver RTL.

module testbench;
  import scpd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int PORTS       = NUM_PORTS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF    = 400;
  localparam int DRAIN       = 16;
  localparam int N_DIR       = 26;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WORD} chk_e;
  typedef enum logic {ROW_REQ, ROW_CFG} row_e;

  typedef struct packed {
    row_e                 kind;
    logic [REQ_W-1:0]     req;
    logic [IDX_W-1:0]     idx;
    logic [BW_W-1:0]      bw;
    chk_e                 chk;
    logic [CHIP_BITS-1:0] bits;
    logic [CNT_W-1:0]     cnt;
  } dir_row_t;

  typedef struct packed {
    logic [CHIP_BITS-1:0] bits;
    logic [CNT_W-1:0]     cnt;
    logic                 last;
  } chip_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [4:0] port_index
  logic [1:0]  s_axis_tuser;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] shift_bits, [11:8] bit_count
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  shift_register_port_chain_driver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  logic [PORTS-1:0] tbl_bits;
  int               tbl_count;
  logic [PORTS-1:0] sent_bits;
  int               sent_count;
  logic [BW_W-1:0]  chip_width;

  chip_word_t pending_words[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  logic       hold_req = 1'b0;

  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_ENABLE,  5'd0,  4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_WORD,  8'h80, 4'd1},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UNKNOWN, 5'd31, 4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_CFG, REQ_ENABLE,  5'd0,  4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_ENABLE,  5'd1,  4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_CFG, REQ_ENABLE,  5'd0,  4'd15, CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd31, 4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_CFG, REQ_ENABLE,  5'd0,  4'd2,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_WORD,  8'h03, 4'd8},
    '{ROW_REQ, REQ_ENABLE,  5'd31, 4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_CFG, REQ_ENABLE,  5'd0,  4'd8,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_MODEL, 8'h00, 4'd0},
    '{ROW_REQ, REQ_DISABLE, 5'd31, 4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_ENABLE,  5'd16, 4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_MODEL, 8'h00, 4'd0},
    '{ROW_CFG, REQ_ENABLE,  5'd0,  4'd1,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_DISABLE, 5'd0,  4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_MODEL, 8'h00, 4'd0},
    '{ROW_CFG, REQ_ENABLE,  5'd0,  4'd7,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_ENABLE,  5'd30, 4'd0,  CHK_NONE,  8'h00, 4'd0},
    '{ROW_REQ, REQ_UPDATE,  5'd0,  4'd0,  CHK_MODEL, 8'h00, 4'd0}
  };

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endfunction

  function automatic void queue_word(chip_word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  task automatic form_chip_words(input logic [REQ_W-1:0] rq, input logic [IDX_W-1:0] ix,
                                 ref chip_word_t words[$]);
    int                   remaining;
    int                   pos;
    int                   n;
    int                   pad;
    int                   slot;
    logic [CHIP_BITS-1:0] word;
    chip_word_t           cw;
    words = {};
    case (rq)
      REQ_ENABLE, REQ_DISABLE: begin
        if (int'(ix) < PORTS) begin
          tbl_bits[ix] = (rq == REQ_ENABLE);
          if (tbl_count < int'(ix) + 1) tbl_count = int'(ix) + 1;
        end
      end
      REQ_UPDATE: begin
        if (!((tbl_bits == sent_bits && tbl_count == sent_count) || tbl_count == 0 ||
              chip_width == 0 || int'(chip_width) > CHIP_BITS)) begin
          remaining = tbl_count;
          pos = tbl_count;
          while (remaining > 0) begin
            n = (remaining >= int'(chip_width)) ? int'(chip_width) : remaining;
            pad = (n == int'(chip_width)) ? CHIP_BITS - n : 0;
            word = '0;
            slot = CHIP_BITS - 1 - pad;
            for (int i = 0; i < n; i++) begin
              pos--;
              word[slot] = tbl_bits[pos];
              slot--;
            end
            remaining -= n;
            cw = '{bits: word, cnt: CNT_W'(pad + n), last: (remaining == 0)};
            words.insert(words.size(), cw);
          end
          sent_bits = tbl_bits;
          sent_count = tbl_count;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] rq, input logic [IDX_W-1:0] ix,
                          input chk_e chk, input logic [CHIP_BITS-1:0] t_bits,
                          input logic [CNT_W-1:0] t_cnt);
    int         gap;
    chip_word_t words[$];
    chip_word_t typed;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, ix};
    s_axis_tuser  <= rq;
    do @(posedge clk_i); while (!s_axis_tready);
    form_chip_words(rq, ix, words);
    typed = '{bits: t_bits, cnt: t_cnt, last: 1'b1};
    case (chk)
      CHK_MODEL: foreach (words[i]) queue_word(words[i]);
      CHK_WORD:  queue_word(typed);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [BW_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BIT_WIDTH;
    pwdata  <= 32'(v);
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    chip_width = v;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(v)) flag_mismatch("bit_width readback", 32'(v), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : rx_pace
    int   run_left;
    int   hold_left;
    logic run_val;
    run_left  = 0;
    hold_left = 0;
    run_val   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_val = ($urandom_range(0, 9) < 6);
          if (run_val) run_left = $urandom_range(1, 40);
          else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(15, 60);
          else run_left = $urandom_range(1, 3);
        end
        run_left--;
        m_axis_tready <= run_val;
      end
    end
  end

  always @(posedge clk_i) begin : word_check
    chip_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("unexpected word", 32'd0, {15'd0, m_axis_tlast, m_axis_tdata});
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata[7:0] !== want.bits)
          flag_mismatch("shift_bits", 32'(want.bits), 32'(m_axis_tdata[7:0]));
        if (m_axis_tdata[11:8] !== want.cnt)
          flag_mismatch("bit_count", 32'(want.cnt), 32'(m_axis_tdata[11:8]));
        if (m_axis_tlast !== want.last)
          flag_mismatch("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** shift_register_port_chain_driver: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int               width;
    int               k;
    int               sent_items;
    logic [REQ_W-1:0] rq;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    chip_width    = BIT_WIDTH_RST;
    tbl_bits      = '0;
    tbl_count     = 0;
    sent_bits     = '0;
    sent_count    = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        cfg_write(dir_rows[i].bw);
      end else begin
        send_req(dir_rows[i].req, dir_rows[i].idx, dir_rows[i].chk,
                 dir_rows[i].bits, dir_rows[i].cnt);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: width = 1;
        1: width = CHIP_BITS;
        default: width = $urandom_range(1, CHIP_BITS);
      endcase
      cfg_write(BW_W'(width));
      if (ph == 2) hold_req = 1'b1;
      sent_items = 0;
      while (sent_items < 50) begin
        if ($urandom_range(0, 9) < 8) begin
          k = $urandom_range(1, 4);
          repeat (k) begin
            rq = ($urandom_range(0, 9) < 6) ? REQ_ENABLE : REQ_DISABLE;
            send_req(rq, IDX_W'($urandom), CHK_MODEL, '0, '0);
          end
          send_req(REQ_UPDATE, IDX_W'($urandom), CHK_MODEL, '0, '0);
          sent_items += k + 1;
        end else begin
          rq = REQ_W'($urandom_range(0, 3));
          send_req(rq, IDX_W'($urandom), CHK_MODEL, '0, '0);
          if (rq != REQ_UNKNOWN) sent_items++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** shift_register_port_chain_driver: PASSED **");
    end else begin
      $display("** shift_register_port_chain_driver: FAILED **");
    end
    $finish;
  end

endmodule
